/* design/ctse_pkg.sv */
// Shared types, constants and coefficient table for the cubic triangle shape evaluator.
package ctse_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = FRAC_BITS + 1;
   localparam int OUT_W     = 24;
   localparam int NODE_W    = 4;
   localparam int NUM_NODES = 10;
   localparam int NUM_POLY  = 3;
   localparam int NUM_MONO  = 10;
   localparam int COEF_W    = 8;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int MONO_W    = 3 * COORD_W;
   localparam int PROD_W    = MONO_W + COEF_W + 1;
   localparam int ACC_W     = PROD_W + 4;
   localparam int RND_SH    = 2 * FRAC_BITS + 1;

   // Cycles from an accepted transfer to the first node issue.
   localparam int ISSUE_LEAD = 2;

   localparam logic [NODE_W-1:0] LAST_NODE  = NODE_W'(NUM_NODES - 1);
   localparam logic [NODE_W-1:0] ACCEPT_CNT = NODE_W'(NUM_NODES - ISSUE_LEAD);

   localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (RND_SH - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(2 ** (OUT_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-(2 ** (OUT_W - 1)));

   // Polynomial slots: value, d/dr, d/ds.
   localparam int P_VAL = 0;
   localparam int P_DR  = 1;
   localparam int P_DS  = 2;

   // Monomial slots: 1, r, s, r^2, rs, s^2, r^3, r^2 s, r s^2, s^3.
   localparam int M_ONE = 0;
   localparam int M_R   = 1;
   localparam int M_S   = 2;
   localparam int M_RR  = 3;
   localparam int M_RS  = 4;
   localparam int M_SS  = 5;
   localparam int M_RRR = 6;
   localparam int M_RRS = 7;
   localparam int M_RSS = 8;
   localparam int M_SSS = 9;

   typedef struct packed {
      logic [COORD_W-1:0] r_coord;
      logic [COORD_W-1:0] s_coord;
   } req_data_type;

   typedef struct packed {
      logic [NODE_W-1:0]       node_index;
      logic signed [OUT_W-1:0] shape_value;
      logic signed [OUT_W-1:0] deriv_r;
      logic signed [OUT_W-1:0] deriv_s;
      logic                    last_node;
   } rsp_data_type;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef coef_type [NUM_MONO-1:0] coef_row_type;
   typedef coef_row_type [NUM_POLY-1:0] coef_set_type;

   function automatic int mono_deg(input int m);
      case (m)
         M_ONE:                return 0;
         M_R, M_S:             return 1;
         M_RR, M_RS, M_SS:     return 2;
         default:              return 3;
      endcase
   endfunction

   function automatic coef_row_type row(input int c0, input int c1, input int c2,
                                        input int c3, input int c4, input int c5,
                                        input int c6, input int c7, input int c8,
                                        input int c9);
      coef_row_type x;
      x[0] = COEF_W'(c0);
      x[1] = COEF_W'(c1);
      x[2] = COEF_W'(c2);
      x[3] = COEF_W'(c3);
      x[4] = COEF_W'(c4);
      x[5] = COEF_W'(c5);
      x[6] = COEF_W'(c6);
      x[7] = COEF_W'(c7);
      x[8] = COEF_W'(c8);
      x[9] = COEF_W'(c9);
      return x;
   endfunction

   // Coefficients in half units, per node, per polynomial, per monomial slot.
   function automatic coef_set_type node_coefs(input logic [NODE_W-1:0] node);
      coef_set_type cs;
      cs = '0;
      case (node)
         NODE_W'(0): begin
            cs[P_VAL] = row(2, -11, -11, 18, 36, 18, -9, -27, -27, -9);
            cs[P_DR]  = row(-11, 36, 36, -27, -54, -27, 0, 0, 0, 0);
            cs[P_DS]  = row(-11, 36, 36, -27, -54, -27, 0, 0, 0, 0);
         end
         NODE_W'(1): begin
            cs[P_VAL] = row(0, 18, 0, -45, -45, 0, 27, 54, 27, 0);
            cs[P_DR]  = row(18, -90, -45, 81, 108, 27, 0, 0, 0, 0);
            cs[P_DS]  = row(0, -45, 0, 54, 54, 0, 0, 0, 0, 0);
         end
         NODE_W'(2): begin
            cs[P_VAL] = row(0, -9, 0, 36, 9, 0, -27, -27, 0, 0);
            cs[P_DR]  = row(-9, 72, 9, -81, -54, 0, 0, 0, 0, 0);
            cs[P_DS]  = row(0, 9, 0, -27, 0, 0, 0, 0, 0, 0);
         end
         NODE_W'(3): begin
            cs[P_VAL] = row(0, 2, 0, -9, 0, 0, 9, 0, 0, 0);
            cs[P_DR]  = row(2, -18, 0, 27, 0, 0, 0, 0, 0, 0);
         end
         NODE_W'(4): begin
            cs[P_VAL] = row(0, 0, 18, 0, -45, -45, 0, 27, 54, 27);
            cs[P_DR]  = row(0, 0, -45, 0, 54, 54, 0, 0, 0, 0);
            cs[P_DS]  = row(18, -45, -90, 27, 108, 81, 0, 0, 0, 0);
         end
         NODE_W'(5): begin
            cs[P_VAL] = row(0, 0, 0, 0, 54, 0, 0, -54, -54, 0);
            cs[P_DR]  = row(0, 0, 54, 0, -108, -54, 0, 0, 0, 0);
            cs[P_DS]  = row(0, 54, 0, -54, -108, 0, 0, 0, 0, 0);
         end
         NODE_W'(6): begin
            cs[P_VAL] = row(0, 0, 0, 0, -9, 0, 0, 27, 0, 0);
            cs[P_DR]  = row(0, 0, -9, 0, 54, 0, 0, 0, 0, 0);
            cs[P_DS]  = row(0, -9, 0, 27, 0, 0, 0, 0, 0, 0);
         end
         NODE_W'(7): begin
            cs[P_VAL] = row(0, 0, -9, 0, 9, 36, 0, 0, -27, -27);
            cs[P_DR]  = row(0, 0, 9, 0, 0, -27, 0, 0, 0, 0);
            cs[P_DS]  = row(-9, 9, 72, 0, -54, -81, 0, 0, 0, 0);
         end
         NODE_W'(8): begin
            cs[P_VAL] = row(0, 0, 0, 0, -9, 0, 0, 0, 27, 0);
            cs[P_DR]  = row(0, 0, -9, 0, 0, 27, 0, 0, 0, 0);
            cs[P_DS]  = row(0, -9, 0, 0, 54, 0, 0, 0, 0, 0);
         end
         NODE_W'(9): begin
            cs[P_VAL] = row(0, 0, 2, 0, 0, -9, 0, 0, 0, 9);
            cs[P_DS]  = row(2, 0, -18, 0, 0, 27, 0, 0, 0, 0);
         end
         default: begin
            cs = '0;
         end
      endcase
      return cs;
   endfunction

endpackage

/* design/cubic_triangle_shape_eval.sv */
// Cubic Lagrange triangle shape functions and derivatives, ten node results per coordinate pair.
// Path: squares, node issue, coefficient fetch, products, partial sums, total, round, each registered.
// Throughput: one node result per cycle, no gaps between pairs. busy holds off a new pair until the
//   squarer is free and the node sequencer, issuing one node per cycle into the pipe, nears its end.
// The receiver cannot stall: every result is on the ports for exactly one cycle.
// Reset clears all valid bits and the sequencer; no data state outlives an item.
module cubic_triangle_shape_eval import ctse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_data_type req_data,
   output logic         rsp_strobe,
   output rsp_data_type rsp_data
);

   // Front: squares on transfer, then the full monomial set.
   logic                s1_valid_ff;
   logic [COORD_W-1:0]  s1_r_ff, s1_s_ff;
   logic [SQ_W-1:0]     s1_rr_ff, s1_ss_ff, s1_rs_ff;
   logic [SQ_W-1:0]     s1_rr_in, s1_ss_in, s1_rs_in;
   logic [MONO_W-1:0]   mono_ff [NUM_MONO];
   logic [MONO_W-1:0]   mono_in [NUM_MONO];

   // Node sequencer.
   logic                seq_active_ff, seq_active_in;
   logic [NODE_W-1:0]   seq_cnt_ff, seq_cnt_in;
   logic                accept;

   // Evaluation pipe: coefficient fetch, products, partial sums, total, round.
   logic                e1_valid_ff;
   logic [NODE_W-1:0]   e1_node_ff;
   coef_set_type        e1_coef_ff;
   logic [MONO_W-1:0]   e1_mono_ff [NUM_MONO];
   logic [MONO_W-1:0]   e1_mono_in [NUM_MONO];

   logic                e2_valid_ff;
   logic [NODE_W-1:0]   e2_node_ff;
   logic signed [PROD_W-1:0] e2_prod_ff [NUM_POLY][NUM_MONO];
   logic signed [PROD_W-1:0] e2_prod_in [NUM_POLY][NUM_MONO];

   logic                e3_valid_ff;
   logic [NODE_W-1:0]   e3_node_ff;
   logic signed [ACC_W-1:0] e3_lo_ff [NUM_POLY];
   logic signed [ACC_W-1:0] e3_hi_ff [NUM_POLY];
   logic signed [ACC_W-1:0] e3_lo_in [NUM_POLY];
   logic signed [ACC_W-1:0] e3_hi_in [NUM_POLY];

   logic                e4_valid_ff;
   logic [NODE_W-1:0]   e4_node_ff;
   logic signed [ACC_W-1:0] e4_sum_ff [NUM_POLY];
   logic signed [ACC_W-1:0] e4_sum_in [NUM_POLY];

   logic                rsp_strobe_ff;
   rsp_data_type        rsp_data_ff, rsp_data_in;

   // Drop the bits below the output LSB (the half-up bias is added in the total), then clamp to the output range.
   function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] q;
      q = x >>> RND_SH;
      if (q > SAT_HI) begin
         q = SAT_HI;
      end else if (q < SAT_LO) begin
         q = SAT_LO;
      end
      return q[OUT_W-1:0];
   endfunction

   // Hold off a new pair while squares are pending or the sequencer is not yet within ISSUE_LEAD
   // nodes of its end, so new monomials land no earlier than the previous pair's last node issues.
   assign busy   = s1_valid_ff || (seq_active_ff && (seq_cnt_ff < ACCEPT_CNT));
   assign accept = start && !busy;

   always_comb begin
      s1_rr_in = SQ_W'(req_data.r_coord) * SQ_W'(req_data.r_coord);
      s1_ss_in = SQ_W'(req_data.s_coord) * SQ_W'(req_data.s_coord);
      s1_rs_in = SQ_W'(req_data.r_coord) * SQ_W'(req_data.s_coord);

      mono_in[M_ONE] = MONO_W'(1);
      mono_in[M_R]   = MONO_W'(s1_r_ff);
      mono_in[M_S]   = MONO_W'(s1_s_ff);
      mono_in[M_RR]  = MONO_W'(s1_rr_ff);
      mono_in[M_RS]  = MONO_W'(s1_rs_ff);
      mono_in[M_SS]  = MONO_W'(s1_ss_ff);
      mono_in[M_RRR] = MONO_W'(s1_rr_ff) * MONO_W'(s1_r_ff);
      mono_in[M_RRS] = MONO_W'(s1_rr_ff) * MONO_W'(s1_s_ff);
      mono_in[M_RSS] = MONO_W'(s1_ss_ff) * MONO_W'(s1_r_ff);
      mono_in[M_SSS] = MONO_W'(s1_ss_ff) * MONO_W'(s1_s_ff);
   end

   // Restart on a fresh monomial set, else advance one node a cycle and drop after the last.
   always_comb begin
      seq_active_in = seq_active_ff;
      seq_cnt_in    = seq_cnt_ff;
      if (s1_valid_ff) begin
         seq_active_in = 1'b1;
         seq_cnt_in    = '0;
      end else if (seq_active_ff) begin
         if (seq_cnt_ff == LAST_NODE) begin
            seq_active_in = 1'b0;
         end else begin
            seq_cnt_in = seq_cnt_ff + NODE_W'(1);
         end
      end
   end

   // Align every monomial to a common scale of 2^-(3*FRAC_BITS); the shifts are constant.
   always_comb begin
      for (int m = 0; m < NUM_MONO; m++) begin
         e1_mono_in[m] = mono_ff[m] << (FRAC_BITS * (3 - mono_deg(m)));
      end
   end

   always_comb begin
      for (int p = 0; p < NUM_POLY; p++) begin
         for (int m = 0; m < NUM_MONO; m++) begin
            e2_prod_in[p][m] = PROD_W'($signed(e1_coef_ff[p][m]))
                             * PROD_W'($signed({1'b0, e1_mono_ff[m]}));
         end
      end
   end

   always_comb begin
      for (int p = 0; p < NUM_POLY; p++) begin
         e3_lo_in[p] = '0;
         e3_hi_in[p] = '0;
         for (int m = 0; m < NUM_MONO / 2; m++) begin
            e3_lo_in[p] = e3_lo_in[p] + ACC_W'(e2_prod_ff[p][m]);
            e3_hi_in[p] = e3_hi_in[p] + ACC_W'(e2_prod_ff[p][m + NUM_MONO / 2]);
         end
      end
   end

   always_comb begin
      for (int p = 0; p < NUM_POLY; p++) begin
         e4_sum_in[p] = e3_lo_ff[p] + e3_hi_ff[p] + RND_BIAS;
      end
   end

   always_comb begin
      rsp_data_in.node_index  = e4_node_ff;
      rsp_data_in.shape_value = round_sat(e4_sum_ff[P_VAL]);
      rsp_data_in.deriv_r     = round_sat(e4_sum_ff[P_DR]);
      rsp_data_in.deriv_s     = round_sat(e4_sum_ff[P_DS]);
      rsp_data_in.last_node   = (e4_node_ff == LAST_NODE);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         seq_active_ff <= 1'b0;
         seq_cnt_ff    <= '0;
         e1_valid_ff   <= 1'b0;
         e2_valid_ff   <= 1'b0;
         e3_valid_ff   <= 1'b0;
         e4_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= accept;
         seq_active_ff <= seq_active_in;
         seq_cnt_ff    <= seq_cnt_in;
         e1_valid_ff   <= seq_active_ff;
         e2_valid_ff   <= e1_valid_ff;
         e3_valid_ff   <= e2_valid_ff;
         e4_valid_ff   <= e3_valid_ff;
         rsp_strobe_ff <= e4_valid_ff;
      end
   end

   // Payload: the monomial set holds for the whole run, the pipe stages move every cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_r_ff  <= req_data.r_coord;
         s1_s_ff  <= req_data.s_coord;
         s1_rr_ff <= s1_rr_in;
         s1_ss_ff <= s1_ss_in;
         s1_rs_ff <= s1_rs_in;
      end
      if (s1_valid_ff) begin
         mono_ff <= mono_in;
      end
      e1_node_ff  <= seq_cnt_ff;
      e1_coef_ff  <= node_coefs(seq_cnt_ff);
      e1_mono_ff  <= e1_mono_in;
      e2_node_ff  <= e1_node_ff;
      e2_prod_ff  <= e2_prod_in;
      e3_node_ff  <= e2_node_ff;
      e3_lo_ff    <= e3_lo_in;
      e3_hi_ff    <= e3_hi_in;
      e4_node_ff  <= e3_node_ff;
      e4_sum_ff   <= e4_sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // A new monomial set only lands while the previous run issues its last node or is done.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (!seq_active_ff || (seq_cnt_ff == LAST_NODE)))
      else $error("monomial set overwritten during a node run");

   // The ten results of one pair come in consecutive cycles in node order.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last_node) |=>
         (rsp_strobe && (rsp_data.node_index == $past(rsp_data.node_index) + NODE_W'(1))))
      else $error("node results not contiguous");

   // The last flag rides only on the final node.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.last_node == (rsp_data.node_index == LAST_NODE)))
      else $error("last flag on wrong node");

   // d/dr of the final node vanishes identically.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_node) |-> (rsp_data.deriv_r == '0))
      else $error("nonzero d/dr on the final node");

endmodule

/* tb/ctse_checker.sv */
// Result checker for the cubic triangle shape evaluator: predicts node results and compares them.
module ctse_checker import ctse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_data_type req_data,
   input  logic         rsp_strobe,
   input  rsp_data_type rsp_data,
   output int           fail_count,
   output int           nodes_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDE_W = 80;

   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam wide_type OUT_HI = (wide_type'(1) <<< (OUT_W - 1)) - wide_type'(1);
   localparam wide_type OUT_LO = -(wide_type'(1) <<< (OUT_W - 1));

   // Monomial order: 1, r, s, r^2, rs, s^2, r^3, r^2 s, r s^2, s^3.
   localparam int R_EXP [0:NUM_MONO-1] = '{0, 1, 0, 2, 1, 0, 3, 2, 1, 0};
   localparam int S_EXP [0:NUM_MONO-1] = '{0, 0, 1, 0, 1, 2, 0, 1, 2, 3};

   // Half-unit coefficients, three rows per node: value, d/dr, d/ds.
   localparam int HALF_COEF [0:NUM_NODES*NUM_POLY-1][0:NUM_MONO-1] = '{
      '{  2, -11, -11,  18,   36,  18,  -9, -27, -27,  -9},
      '{-11,  36,  36, -27,  -54, -27,   0,   0,   0,   0},
      '{-11,  36,  36, -27,  -54, -27,   0,   0,   0,   0},
      '{  0,  18,   0, -45,  -45,   0,  27,  54,  27,   0},
      '{ 18, -90, -45,  81,  108,  27,   0,   0,   0,   0},
      '{  0, -45,   0,  54,   54,   0,   0,   0,   0,   0},
      '{  0,  -9,   0,  36,    9,   0, -27, -27,   0,   0},
      '{ -9,  72,   9, -81,  -54,   0,   0,   0,   0,   0},
      '{  0,   9,   0, -27,    0,   0,   0,   0,   0,   0},
      '{  0,   2,   0,  -9,    0,   0,   9,   0,   0,   0},
      '{  2, -18,   0,  27,    0,   0,   0,   0,   0,   0},
      '{  0,   0,   0,   0,    0,   0,   0,   0,   0,   0},
      '{  0,   0,  18,   0,  -45, -45,   0,  27,  54,  27},
      '{  0,   0, -45,   0,   54,  54,   0,   0,   0,   0},
      '{ 18, -45, -90,  27,  108,  81,   0,   0,   0,   0},
      '{  0,   0,   0,   0,   54,   0,   0, -54, -54,   0},
      '{  0,   0,  54,   0, -108, -54,   0,   0,   0,   0},
      '{  0,  54,   0, -54, -108,   0,   0,   0,   0,   0},
      '{  0,   0,   0,   0,   -9,   0,   0,  27,   0,   0},
      '{  0,   0,  -9,   0,   54,   0,   0,   0,   0,   0},
      '{  0,  -9,   0,  27,    0,   0,   0,   0,   0,   0},
      '{  0,   0,  -9,   0,    9,  36,   0,   0, -27, -27},
      '{  0,   0,   9,   0,    0, -27,   0,   0,   0,   0},
      '{ -9,   9,  72,   0,  -54, -81,   0,   0,   0,   0},
      '{  0,   0,   0,   0,   -9,   0,   0,   0,  27,   0},
      '{  0,   0,  -9,   0,    0,  27,   0,   0,   0,   0},
      '{  0,  -9,   0,   0,   54,   0,   0,   0,   0,   0},
      '{  0,   0,   2,   0,    0,  -9,   0,   0,   0,   9},
      '{  0,   0,   0,   0,    0,   0,   0,   0,   0,   0},
      '{  2,   0, -18,   0,    0,  27,   0,   0,   0,   0}
   };

   rsp_data_type node_results_due[$];

   // Sum exactly in units of 2^-(2F+1) output steps, round half up, then clamp.
   function automatic logic signed [OUT_W-1:0] eval_shape_poly(
      input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] s, input int row_idx);
      wide_type r_pow [0:3];
      wide_type s_pow [0:3];
      wide_type acc, term, rounded;
      int       k, m, deg;
      r_pow[0] = wide_type'(1);
      s_pow[0] = wide_type'(1);
      for (k = 1; k < 4; k++) begin
         r_pow[k] = r_pow[k-1] * $signed({1'b0, r});
         s_pow[k] = s_pow[k-1] * $signed({1'b0, s});
      end
      acc = '0;
      for (m = 0; m < NUM_MONO; m++) begin
         deg  = R_EXP[m] + S_EXP[m];
         term = r_pow[R_EXP[m]] * s_pow[S_EXP[m]] * wide_type'(HALF_COEF[row_idx][m]);
         acc  = acc + (term <<< (FRAC_BITS * (3 - deg)));
      end
      rounded = (acc + (wide_type'(1) <<< (2 * FRAC_BITS))) >>> (2 * FRAC_BITS + 1);
      if (rounded > OUT_HI) rounded = OUT_HI;
      if (rounded < OUT_LO) rounded = OUT_LO;
      return rounded[OUT_W-1:0];
   endfunction

   task automatic compare_field(input string field, input int node,
                                input longint want, input longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t ns: node %0d %s mismatch, expected %0d, actual %0d",
                  $time, node, field, want, got);
      end
   endtask

   initial begin
      fail_count = 0;
      nodes_due  = 0;
   end

   always @(posedge clock) begin : watch
      rsp_data_type want;
      int           n;
      if (!reset) begin
         if (rsp_strobe) begin
            if (node_results_due.size() == 0) begin
               fail_count++;
               $display("%0t ns: unexpected result, expected none, actual node %0d",
                        $time, rsp_data.node_index);
            end else begin
               want = node_results_due.pop_front();
               compare_field("node_index", want.node_index, want.node_index,
                             rsp_data.node_index);
               compare_field("shape_value", want.node_index, want.shape_value,
                             rsp_data.shape_value);
               compare_field("deriv_r", want.node_index, want.deriv_r, rsp_data.deriv_r);
               compare_field("deriv_s", want.node_index, want.deriv_s, rsp_data.deriv_s);
               compare_field("last_node", want.node_index, want.last_node,
                             rsp_data.last_node);
            end
         end
         if (start && !busy) begin
            for (n = 0; n < NUM_NODES; n++) begin
               want.node_index  = NODE_W'(n);
               want.shape_value = eval_shape_poly(req_data.r_coord, req_data.s_coord,
                                                  n * NUM_POLY + P_VAL);
               want.deriv_r     = eval_shape_poly(req_data.r_coord, req_data.s_coord,
                                                  n * NUM_POLY + P_DR);
               want.deriv_s     = eval_shape_poly(req_data.r_coord, req_data.s_coord,
                                                  n * NUM_POLY + P_DS);
               want.last_node   = (n == NUM_NODES - 1);
               node_results_due.push_back(want);
            end
         end
      end
      nodes_due <= node_results_due.size();
   end

endmodule

/* tb/cubic_triangle_shape_eval_tb.sv */
// Testbench top for the cubic triangle shape evaluator: stimulus, checker hookup and verdict.
module cubic_triangle_shape_eval_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ctse_pkg::*;

   localparam int NUM_DIRECTED = 23;
   localparam int NUM_RANDOM   = 127;
   localparam int COORD_ONE    = 1 << FRAC_BITS;
   localparam int THIRD        = 21845;
   localparam int TWO_THIRDS   = 43691;

   // Directed pairs: the ten node positions, an edge midpoint, tiny values where
   // half-step ties show up, the unit corners and coordinates outside the
   // triangle that drive the outputs into saturation.
   localparam int DIR_R [0:NUM_DIRECTED-1] = '{
      0, COORD_ONE, 0, THIRD, TWO_THIRDS, TWO_THIRDS, THIRD, 0, 0, THIRD,
      32768, 1, 0, 1, 3, 65535, COORD_ONE, 131071, 0, 131071,
      COORD_ONE, 98304, 12345};
   localparam int DIR_S [0:NUM_DIRECTED-1] = '{
      0, 0, COORD_ONE, 0, 0, THIRD, TWO_THIRDS, TWO_THIRDS, THIRD, THIRD,
      32768, 0, 1, 1, 5, 1, COORD_ONE, 0, 131071, 131071,
      131071, 12345, 65535};

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_data_type req_data;
   logic         rsp_strobe;
   rsp_data_type rsp_data;
   int           fail_count;
   int           nodes_due;
   int           burst_left;

   cubic_triangle_shape_eval uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // The checker watches both channels, predicts every node result and counts
   // mismatches; the top only drives stimulus and reads the counts at the end.
   ctse_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .nodes_due  (nodes_due)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop well beyond the slowest correct run (about 150 pairs, each followed
   // by at most the longest gap, plus the drain).
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Present one coordinate pair, hold it until the transfer, then idle.
   // Called at a falling edge; returns at a falling edge. When no gap follows,
   // start simply stays high for the next pair.
   task automatic transfer_pair(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] s);
      int gap, roll;
      req_data.r_coord = r;
      req_data.s_coord = s;
      start            = 1'b1;
      // Hold the request until an edge finds the evaluator not busy.
      do @(posedge clock); while (busy);
      @(negedge clock);
      // Mostly short gaps, a few long ones, and bursts with no gaps at all so
      // that requests land on every phase of the node sequence.
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            burst_left = $urandom_range(10, 25);
            gap        = 0;
         end else if (roll < 45) begin
            gap = 0;
         end else if (roll < 85) begin
            gap = $urandom_range(1, 9);
         end else begin
            gap = $urandom_range(15, 60);
         end
      end
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      logic [COORD_W-1:0] r, s;
      int                 i, pick;
      // Drive every input to a known value before the first edge.
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < NUM_DIRECTED; i++) begin
         transfer_pair(COORD_W'(DIR_R[i]), COORD_W'(DIR_S[i]));
      end

      // Random pairs: mostly inside the reference triangle, some on its
      // boundary, the rest anywhere in the 17-bit coordinate range.
      repeat (NUM_RANDOM) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            r = COORD_W'($urandom_range(0, COORD_ONE));
            s = COORD_W'($urandom_range(0, COORD_ONE - r));
         end else if (pick < 80) begin
            r = COORD_W'($urandom_range(0, COORD_ONE));
            case ($urandom_range(0, 2))
               0: s = COORD_W'(COORD_ONE - r);
               1: s = '0;
               default: begin
                  s = r;
                  r = '0;
               end
            endcase
         end else begin
            r = COORD_W'($urandom);
            s = COORD_W'($urandom);
         end
         transfer_pair(r, s);
      end
      start = 1'b0;

      // Drain: wait for every predicted node result, then allow for strays.
      while (nodes_due != 0) @(negedge clock);
      repeat (30) @(negedge clock);

      if (fail_count == 0 && nodes_due == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/ctse_pkg.sv
design/cubic_triangle_shape_eval.sv
tb/ctse_checker.sv
tb/cubic_triangle_shape_eval_tb.sv
